### design/ry420_pkg.sv
// shared types and constants for the rgb to yuv 4:2:0 converter
package ry420_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = $clog2(MAX_DIMENSION);
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int PIX_W         = 8;
  localparam int KIND_W        = 2;
  localparam int SUM_W         = 17;

  localparam logic [SUM_W-1:0] C_Y_R     = SUM_W'(66);
  localparam logic [SUM_W-1:0] C_Y_G     = SUM_W'(129);
  localparam logic [SUM_W-1:0] C_Y_B     = SUM_W'(25);
  localparam logic [SUM_W-1:0] C_U_R     = SUM_W'(38);
  localparam logic [SUM_W-1:0] C_U_G     = SUM_W'(74);
  localparam logic [SUM_W-1:0] C_UV_MAX  = SUM_W'(112);
  localparam logic [SUM_W-1:0] C_V_G     = SUM_W'(94);
  localparam logic [SUM_W-1:0] C_V_B     = SUM_W'(18);
  localparam logic [SUM_W-1:0] C_ROUND   = SUM_W'(128);
  localparam logic [SUM_W-1:0] C_C_BIAS  = SUM_W'(128 + 32768);
  localparam logic [PIX_W-1:0] C_Y_OFF   = PIX_W'(16);

  localparam logic [DIM_W-1:0] RST_LAST_COL = DIM_W'(640 - 1);
  localparam logic [DIM_W-1:0] RST_LAST_ROW = DIM_W'(480 - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = CFG_IDX_W'(0),
    REG_FRAME_HEIGHT = CFG_IDX_W'(1)
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = KIND_W'(0),
    KIND_U    = KIND_W'(1),
    KIND_V    = KIND_W'(2)
  } chroma_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    chroma_kind_t     kind;
    logic             last;
  } pix_stage_t;

  // last column or row index for a configured size, zero taken as one
  function automatic logic [DIM_W-1:0] last_index(input logic [CFG_W-1:0] size);
    logic [DIM_W-1:0] res;
    if (size == '0) begin
      res = '0;
    end else if (size > CFG_W'(MAX_DIMENSION)) begin
      res = DIM_W'(MAX_DIMENSION - 1);
    end else begin
      res = DIM_W'(size - CFG_W'(1));
    end
    return res;
  endfunction

endpackage

### design/rgb_to_yuv420_converter_core.sv
// rgb24 to bt.601 yuv 4:2:0 converter, one pixel per beat
//
// in_*  : one rgb24 pixel per beat in raster order
// out_* : one result beat per pixel: luma, a point-decimated chroma sample
//         (u on even rows, v on odd rows, even columns only) and tlast on
//         the last pixel of the frame
// cfg_* : frame width (index 0) and frame height (index 1), written while idle
//
// pipeline: pixel register, then result register, with the
// constant-coefficient sums between them
// throughput: one pixel per cycle while out_tready is high, set by the
// two-entry pipeline; position counters advance on the input beat
// reset: counters go to the top-left pixel, size returns to 640 x 480, the
// pipeline empties
// stall: with out_tready low the result register holds, the pixel register
// still fills, then in_tready drops until the result is taken
module rgb_to_yuv420_converter_core
  import ry420_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // red, green, blue
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // luma, chroma
  output logic [KIND_W-1:0]    out_tuser,  // chroma_kind
  output logic                 out_tlast,  // frame_end
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [DIM_W-1:0] last_col_r, last_col_nxt;
  logic [DIM_W-1:0] last_row_r, last_row_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  pix_stage_t       s1_r, s1_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] luma_r, luma_nxt;
  logic [PIX_W-1:0] chroma_r, chroma_nxt;
  chroma_kind_t     kind_r;
  logic             last_r;

  logic             out_free;
  logic             s1_move;
  logic             in_beat;
  logic             col_end;
  logic             row_end;
  logic [SUM_W-1:0] r_x, g_x, b_x;
  logic [SUM_W-1:0] y_sum, u_sum, v_sum;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_move;
  assign in_beat   = in_tvalid && in_tready;
  assign col_end   = col_r >= last_col_r;
  assign row_end   = row_r >= last_row_r;

  // configuration decode
  always_comb begin
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  last_col_nxt = last_index(cfg_data);
        REG_FRAME_HEIGHT: last_row_nxt = last_index(cfg_data);
        default: ;
      endcase
    end
  end

  // position tracking and pixel register
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_beat) begin
      s1_valid_nxt = 1'b1;
      s1_nxt.red   = in_tdata[7:0];
      s1_nxt.green = in_tdata[15:8];
      s1_nxt.blue  = in_tdata[23:16];
      s1_nxt.last  = col_end && row_end;
      if (col_r[0]) begin
        s1_nxt.kind = KIND_NONE;
      end else if (row_r[0]) begin
        s1_nxt.kind = KIND_V;
      end else begin
        s1_nxt.kind = KIND_U;
      end
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + DIM_W'(1);
      end else begin
        col_nxt = col_r + DIM_W'(1);
      end
    end
  end

  // constant-coefficient sums, modulo 2^17, final values fit 16 bits
  assign r_x   = SUM_W'(s1_r.red);
  assign g_x   = SUM_W'(s1_r.green);
  assign b_x   = SUM_W'(s1_r.blue);
  assign y_sum = C_Y_R * r_x + C_Y_G * g_x + C_Y_B * b_x + C_ROUND;
  assign u_sum = C_UV_MAX * b_x + C_C_BIAS - C_U_R * r_x - C_U_G * g_x;
  assign v_sum = C_UV_MAX * r_x + C_C_BIAS - C_V_G * g_x - C_V_B * b_x;

  always_comb begin
    out_valid_nxt = out_valid_r;
    luma_nxt      = y_sum[15:8] + C_Y_OFF;
    case (s1_r.kind)
      KIND_U:  chroma_nxt = u_sum[15:8];
      KIND_V:  chroma_nxt = v_sum[15:8];
      default: chroma_nxt = '0;
    endcase
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r  <= RST_LAST_COL;
      last_row_r  <= RST_LAST_ROW;
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      last_col_r  <= last_col_nxt;
      last_row_r  <= last_row_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (s1_move) begin
      luma_r   <= luma_nxt;
      chroma_r <= chroma_nxt;
      kind_r   <= s1_r.kind;
      last_r   <= s1_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {chroma_r, luma_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

### design/ry420_checker.sv
// port-level assertions for the rgb to yuv 4:2:0 converter
module ry420_port_checker
  import ry420_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [15:0]       out_tdata,
  input logic [KIND_W-1:0] out_tuser,
  input logic              out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == KIND_NONE || out_tuser == KIND_U || out_tuser == KIND_V)
    else $error("unused chroma kind code");

  a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_NONE |-> out_tdata[15:8] == '0)
    else $error("chroma byte set without a chroma sample");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] >= 8'd16 && out_tdata[7:0] <= 8'd235)
    else $error("luma outside 16..235");

endmodule

bind rgb_to_yuv420_converter_core ry420_port_checker u_ry420_checker (.*);
